// File: hdl/rti_pkg.sv
// Shared types and constants of the ray/triangle intersection pipeline.
// Word structs, register indexes and the fixed datapath widths.
// No dependencies.
package rti_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EPSILON  = 2'd3;

    localparam int COORD_W   = 32;
    localparam int EDGE_W    = 33;
    localparam int CP_W      = 66;
    localparam int CR_W      = 67;
    localparam int LO_BITS   = 32;
    localparam int PLO_W     = 66;
    localparam int PHI_W     = 68;
    localparam int DOT_W     = 102;
    localparam int DEN_W     = 101;
    localparam int EPS_W     = 16;
    localparam int DSPLIT    = 34;
    localparam int EP_W      = 50;
    localparam int DIST_W    = 31;
    localparam int BARY_W    = 17;
    localparam int BARY_FRAC = 16;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    typedef struct packed {
        logic signed [COORD_W-1:0] dir_x;
        logic signed [COORD_W-1:0] dir_y;
        logic signed [COORD_W-1:0] dir_z;
        logic signed [COORD_W-1:0] vert0_x;
        logic signed [COORD_W-1:0] vert0_y;
        logic signed [COORD_W-1:0] vert0_z;
        logic signed [COORD_W-1:0] vert1_x;
        logic signed [COORD_W-1:0] vert1_y;
        logic signed [COORD_W-1:0] vert1_z;
        logic signed [COORD_W-1:0] vert2_x;
        logic signed [COORD_W-1:0] vert2_y;
        logic signed [COORD_W-1:0] vert2_z;
    } t_ray_in;

    typedef struct packed {
        logic              hit;
        logic [DIST_W-1:0] distance;
        logic [BARY_W-1:0] bary_u;
        logic [BARY_W-1:0] bary_v;
    } t_ray_out;

    typedef struct packed {
        logic hit;
        logic sat;
    } t_div_side;

endpackage

// File: hdl/rti_div.sv
// Pipelined restoring divider: one quotient bit per stage for t, u and v,
// all sharing the determinant as divisor. Depends on rti_pkg.
module rti_div #(
    parameter int DEN_W = 101,
    parameter int NT_W  = 117,
    parameter int NU_W  = 117
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_vld,
    input  rti_pkg::t_div_side i_side,
    input  logic [DEN_W-1:0]   i_den,
    input  logic [NT_W-1:0]    i_nt,
    input  logic [NU_W-1:0]    i_nu,
    input  logic [NU_W-1:0]    i_nv,
    output logic               o_vld,
    output rti_pkg::t_div_side o_side,
    output logic [rti_pkg::DIST_W-1:0] o_qt,
    output logic [rti_pkg::BARY_W-1:0] o_qu,
    output logic [rti_pkg::BARY_W-1:0] o_qv
);
    import rti_pkg::*;

    localparam int DEPTH = DIST_W;
    localparam int CT_W  = DEN_W + DIST_W;
    localparam int CU_W  = DEN_W + BARY_W;

    logic              r_vld  [DEPTH];
    t_div_side         r_side [DEPTH];
    logic [DEN_W-1:0]  r_den  [DEPTH];
    logic [CT_W-1:0]   r_rt   [DEPTH];
    logic [CU_W-1:0]   r_ru   [DEPTH];
    logic [CU_W-1:0]   r_rv   [DEPTH];
    logic [DIST_W-1:0] r_qt   [DEPTH];
    logic [BARY_W-1:0] r_qu   [DEPTH];
    logic [BARY_W-1:0] r_qv   [DEPTH];

    for (genvar j = 0; j < DEPTH; j++) begin : g_stage
        localparam int KT = DIST_W - 1 - j;
        logic              w_vld;
        t_div_side         w_side;
        logic [DEN_W-1:0]  w_den;
        logic [CT_W-1:0]   w_rt, w_ct, n_rt;
        logic [CU_W-1:0]   w_ru, w_rv, n_ru, n_rv;
        logic [DIST_W-1:0] w_qt, n_qt;
        logic [BARY_W-1:0] w_qu, w_qv, n_qu, n_qv;

        if (j == 0) begin : g_first
            assign w_vld  = i_vld;
            assign w_side = i_side;
            assign w_den  = i_den;
            assign w_rt   = CT_W'(i_nt);
            assign w_ru   = CU_W'(i_nu);
            assign w_rv   = CU_W'(i_nv);
            assign w_qt   = '0;
            assign w_qu   = '0;
            assign w_qv   = '0;
        end else begin : g_next
            assign w_vld  = r_vld[j-1];
            assign w_side = r_side[j-1];
            assign w_den  = r_den[j-1];
            assign w_rt   = r_rt[j-1];
            assign w_ru   = r_ru[j-1];
            assign w_rv   = r_rv[j-1];
            assign w_qt   = r_qt[j-1];
            assign w_qu   = r_qu[j-1];
            assign w_qv   = r_qv[j-1];
        end

        assign w_ct = CT_W'(w_den) << KT;
        always_comb begin
            if (w_rt >= w_ct) begin
                n_rt = w_rt - w_ct;
                n_qt = w_qt | (DIST_W'(1) << KT);
            end else begin
                n_rt = w_rt;
                n_qt = w_qt;
            end
        end

        if (j < BARY_W) begin : g_bary
            localparam int KU = BARY_W - 1 - j;
            logic [CU_W-1:0] w_cu;
            assign w_cu = CU_W'(w_den) << KU;
            always_comb begin
                if (w_ru >= w_cu) begin
                    n_ru = w_ru - w_cu;
                    n_qu = w_qu | (BARY_W'(1) << KU);
                end else begin
                    n_ru = w_ru;
                    n_qu = w_qu;
                end
                if (w_rv >= w_cu) begin
                    n_rv = w_rv - w_cu;
                    n_qv = w_qv | (BARY_W'(1) << KU);
                end else begin
                    n_rv = w_rv;
                    n_qv = w_qv;
                end
            end
        end else begin : g_hold
            assign n_ru = w_ru;
            assign n_rv = w_rv;
            assign n_qu = w_qu;
            assign n_qv = w_qv;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (i_en) begin
                r_vld[j] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[j] <= w_side;
                r_den[j]  <= w_den;
                r_rt[j]   <= n_rt;
                r_ru[j]   <= n_ru;
                r_rv[j]   <= n_rv;
                r_qt[j]   <= n_qt;
                r_qu[j]   <= n_qu;
                r_qv[j]   <= n_qv;
            end
        end
    end

    assign o_vld  = r_vld[DEPTH-1];
    assign o_side = r_side[DEPTH-1];
    assign o_qt   = r_qt[DEPTH-1];
    assign o_qu   = r_qu[DEPTH-1];
    assign o_qv   = r_qv[DEPTH-1];

endmodule

// File: hdl/ray_triangle_intersection.sv
// Top level of the ray/triangle intersection pipeline (backface culled).
// Depends on rti_pkg and rti_div.
//
// Usage:
//  - Input channel (i_in_valid / o_in_ready / i_in_word) takes one word per
//    cycle: ray direction and three triangle vertices, signed fixed point.
//  - Output channel (o_out_valid / i_out_ready / o_out_word) returns one word
//    per input word, in order: hit flag, distance t, barycentric u and v;
//    all values are zero on a miss, t saturates at its maximum.
//  - Configuration port (i_cfg_we / i_cfg_idx / i_cfg_data) sets the ray
//    origin and epsilon; write only while no word is in flight.
//  - Throughput is one word per cycle unless the receiver stalls. Stages:
//    8 for edges, cross products, split dot products and tests, then 31 of
//    the bit-per-stage divider that forms t (u and v finish within them).
//  - Reset empties the pipeline, clears the origin and sets epsilon to 1.
//  - When the receiver stalls, the whole pipeline holds and o_in_ready
//    drops; nothing is lost or repeated. An empty output stage keeps
//    o_in_ready high.
module ray_triangle_intersection #(
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  rti_pkg::t_ray_in                   i_in_word,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output rti_pkg::t_ray_out                  o_out_word,
    input  logic                               i_cfg_we,
    input  logic [rti_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [rti_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import rti_pkg::*;

    localparam int F    = COORD_FRAC_BITS;
    localparam int NT_W = DEN_W + F;
    localparam int NU_W = DEN_W + BARY_FRAC;
    localparam int EW   = NT_W + EPS_W;
    localparam int CT_W = DEN_W + DIST_W;

    logic signed [COORD_W-1:0] r_org [3];
    logic [EPS_W-1:0]          r_eps;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org[0] <= '0;
            r_org[1] <= '0;
            r_org[2] <= '0;
            r_eps    <= EPS_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ORIGIN_X: r_org[0] <= i_cfg_data;
                CFG_ORIGIN_Y: r_org[1] <= i_cfg_data;
                CFG_ORIGIN_Z: r_org[2] <= i_cfg_data;
                CFG_EPSILON:  r_eps    <= i_cfg_data[EPS_W-1:0];
                default: ;
            endcase
        end
    end

    logic w_adv;
    assign w_adv      = !o_out_valid || i_out_ready;
    assign o_in_ready = w_adv;

    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7, r_v8;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
            r_v8 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= i_in_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            r_v7 <= r_v6;
            r_v8 <= r_v7;
        end
    end

    // stage 1: edges and origin offset
    logic signed [COORD_W-1:0] w_d [3], w_p0 [3], w_p1 [3], w_p2 [3];
    logic signed [COORD_W-1:0] r1_d [3];
    logic signed [EDGE_W-1:0]  r1_e1 [3], r1_e2 [3], r1_s [3];

    always_comb begin
        w_d[0]  = i_in_word.dir_x;
        w_d[1]  = i_in_word.dir_y;
        w_d[2]  = i_in_word.dir_z;
        w_p0[0] = i_in_word.vert0_x;
        w_p0[1] = i_in_word.vert0_y;
        w_p0[2] = i_in_word.vert0_z;
        w_p1[0] = i_in_word.vert1_x;
        w_p1[1] = i_in_word.vert1_y;
        w_p1[2] = i_in_word.vert1_z;
        w_p2[0] = i_in_word.vert2_x;
        w_p2[1] = i_in_word.vert2_y;
        w_p2[2] = i_in_word.vert2_z;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r1_d[i]  <= w_d[i];
                r1_e1[i] <= EDGE_W'(w_p1[i]) - EDGE_W'(w_p0[i]);
                r1_e2[i] <= EDGE_W'(w_p2[i]) - EDGE_W'(w_p0[i]);
                r1_s[i]  <= EDGE_W'(r_org[i]) - EDGE_W'(w_p0[i]);
            end
        end
    end

    // stages 2 and 3: cross products p = d x e2 and q = s x e1
    logic signed [COORD_W-1:0] r2_d [3], r3_d [3];
    logic signed [EDGE_W-1:0]  r2_e1 [3], r2_e2 [3], r2_s [3];
    logic signed [EDGE_W-1:0]  r3_e1 [3], r3_e2 [3], r3_s [3];
    logic signed [CP_W-1:0]    r2_pa [3], r2_pb [3], r2_qa [3], r2_qb [3];
    logic signed [CR_W-1:0]    r3_p [3], r3_q [3];

    for (genvar i = 0; i < 3; i++) begin : g_cross
        localparam int J = (i + 1) % 3;
        localparam int K = (i + 2) % 3;
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r2_pa[i] <= CP_W'(r1_d[J]) * CP_W'(r1_e2[K]);
                r2_pb[i] <= CP_W'(r1_d[K]) * CP_W'(r1_e2[J]);
                r2_qa[i] <= CP_W'(r1_s[J]) * CP_W'(r1_e1[K]);
                r2_qb[i] <= CP_W'(r1_s[K]) * CP_W'(r1_e1[J]);
                r2_d[i]  <= r1_d[i];
                r2_e1[i] <= r1_e1[i];
                r2_e2[i] <= r1_e2[i];
                r2_s[i]  <= r1_s[i];
                r3_p[i]  <= CR_W'(r2_pa[i]) - CR_W'(r2_pb[i]);
                r3_q[i]  <= CR_W'(r2_qa[i]) - CR_W'(r2_qb[i]);
                r3_d[i]  <= r2_d[i];
                r3_e1[i] <= r2_e1[i];
                r3_e2[i] <= r2_e2[i];
                r3_s[i]  <= r2_s[i];
            end
        end
    end

    // stages 4 to 6: det = e1.p, un = s.p, vn = d.q, tn = e2.q
    logic signed [EDGE_W-1:0] w4_a [4][3];
    logic signed [CR_W-1:0]   w4_b [4][3];
    logic signed [PLO_W-1:0]  r4_lo [4][3];
    logic signed [PHI_W-1:0]  r4_hi [4][3];
    logic signed [DOT_W-1:0]  r5_m [4][3];
    logic signed [DOT_W-1:0]  r6_dot [4];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w4_a[0][i] = r3_e1[i];
            w4_b[0][i] = r3_p[i];
            w4_a[1][i] = r3_s[i];
            w4_b[1][i] = r3_p[i];
            w4_a[2][i] = EDGE_W'(r3_d[i]);
            w4_b[2][i] = r3_q[i];
            w4_a[3][i] = r3_e2[i];
            w4_b[3][i] = r3_q[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int n = 0; n < 4; n++) begin
                for (int i = 0; i < 3; i++) begin
                    r4_lo[n][i] <= PLO_W'(w4_a[n][i])
                                 * PLO_W'($signed({1'b0, w4_b[n][i][LO_BITS-1:0]}));
                    r4_hi[n][i] <= PHI_W'(w4_a[n][i])
                                 * PHI_W'($signed(w4_b[n][i][CR_W-1:LO_BITS]));
                    r5_m[n][i]  <= (DOT_W'(r4_hi[n][i]) <<< LO_BITS)
                                 + DOT_W'(r4_lo[n][i]);
                end
                r6_dot[n] <= r5_m[n][0] + r5_m[n][1] + r5_m[n][2];
            end
        end
    end

    // stage 7: range tests, epsilon times det in partial products
    logic signed [DOT_W-1:0] w7_epsw;
    logic signed [DOT_W:0]   w7_uv;
    logic                    w7_pre;
    logic                    r7_pre;
    logic signed [DOT_W-1:0] r7_det, r7_un, r7_vn, r7_tn;
    logic [EP_W-1:0]         r7_ep [3];

    always_comb begin
        w7_epsw = DOT_W'(r_eps) << (2 * F);
        w7_uv   = (DOT_W+1)'(r6_dot[1]) + (DOT_W+1)'(r6_dot[2]);
        w7_pre  = (r6_dot[0] > 0) && (r6_dot[0] >= w7_epsw)
               && !r6_dot[1][DOT_W-1] && !(r6_dot[1] > r6_dot[0])
               && !r6_dot[2][DOT_W-1] && !(w7_uv > (DOT_W+1)'(r6_dot[0]));
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r7_pre   <= w7_pre;
            r7_det   <= r6_dot[0];
            r7_un    <= r6_dot[1];
            r7_vn    <= r6_dot[2];
            r7_tn    <= r6_dot[3];
            r7_ep[0] <= EP_W'(r_eps) * EP_W'(r6_dot[0][DSPLIT-1:0]);
            r7_ep[1] <= EP_W'(r_eps) * EP_W'(r6_dot[0][2*DSPLIT-1:DSPLIT]);
            r7_ep[2] <= EP_W'(r_eps) * EP_W'(r6_dot[0][DEN_W-1:2*DSPLIT]);
        end
    end

    // stage 8: distance test, saturation, divider operands
    logic [EW-1:0]    w8_ed;
    logic [NT_W-1:0]  w8_nt;
    logic [DEN_W-1:0] w8_den;
    logic             w8_tok, w8_sat;
    logic             r8_hit, r8_sat;
    logic [DEN_W-1:0] r8_den;
    logic [NT_W-1:0]  r8_nt;
    logic [NU_W-1:0]  r8_nu, r8_nv;

    always_comb begin
        w8_ed  = EW'(r7_ep[0]) + (EW'(r7_ep[1]) << DSPLIT)
               + (EW'(r7_ep[2]) << (2 * DSPLIT));
        w8_nt  = NT_W'(r7_tn[DEN_W-1:0]) << F;
        w8_den = r7_det[DEN_W-1:0];
        w8_tok = !r7_tn[DOT_W-1] && (w8_ed < EW'(w8_nt));
        w8_sat = CT_W'(w8_nt) >= (CT_W'(w8_den) << DIST_W);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r8_hit <= r7_pre && w8_tok;
            r8_sat <= w8_sat;
            r8_den <= w8_den;
            r8_nt  <= w8_nt;
            r8_nu  <= NU_W'(r7_un[DEN_W-1:0]) << BARY_FRAC;
            r8_nv  <= NU_W'(r7_vn[DEN_W-1:0]) << BARY_FRAC;
        end
    end

    t_div_side         w_side_in, w_side_out;
    logic [DIST_W-1:0] w_qt;
    logic [BARY_W-1:0] w_qu, w_qv;

    assign w_side_in.hit = r8_hit;
    assign w_side_in.sat = r8_sat;

    rti_div #(
        .DEN_W (DEN_W),
        .NT_W  (NT_W),
        .NU_W  (NU_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_vld   (r_v8),
        .i_side  (w_side_in),
        .i_den   (r8_den),
        .i_nt    (r8_nt),
        .i_nu    (r8_nu),
        .i_nv    (r8_nv),
        .o_vld   (o_out_valid),
        .o_side  (w_side_out),
        .o_qt    (w_qt),
        .o_qu    (w_qu),
        .o_qv    (w_qv)
    );

    always_comb begin
        o_out_word.hit      = w_side_out.hit;
        o_out_word.distance = '0;
        o_out_word.bary_u   = '0;
        o_out_word.bary_v   = '0;
        if (w_side_out.hit) begin
            o_out_word.distance = w_side_out.sat ? DIST_MAX : w_qt;
            o_out_word.bary_u   = w_qu;
            o_out_word.bary_v   = w_qv;
        end
    end

endmodule
